// ----- design/base_error_histogram_core_defines.svh -----
// Assertion macros for the base error histogram core.
`ifndef BASE_ERROR_HISTOGRAM_CORE_DEFINES_SVH
`define BASE_ERROR_HISTOGRAM_CORE_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define BEH_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a condition in the cycle after its trigger.
`define BEH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/beh_pkg.sv -----
// Types and constants shared by the base error histogram modules.
package beh_pkg;

	// Field widths of the stream items
	localparam int ACT_W    = 3;
	localparam int BASE_W   = 3;
	localparam int QUAL_W   = 6;
	localparam int FILE_W   = 2;
	localparam int KEY_W    = 5;
	localparam int IDX_W    = 6;
	localparam int OUT_W    = 32;
	localparam int S_DATA_W = 32;
	localparam int M_DATA_W = 40;

	// Key table layout
	localparam int KEYS = 25;
	localparam logic [KEY_W-1:0]  KEY_GAP_GAP  = 5'd24;
	localparam logic [KEY_W-1:0]  KEY_INS_BASE = 5'd20;
	localparam logic [BASE_W-1:0] SYM_GAP      = 3'd4;

	// Request kinds carried in tuser
	localparam logic [ACT_W-1:0] ACT_BASE      = 3'd0;
	localparam logic [ACT_W-1:0] ACT_DELETION  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_REDUNDANT = 3'd2;
	localparam logic [ACT_W-1:0] ACT_READ_ERR  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_READ_HIST = 3'd4;

	// Counted indel lengths
	localparam logic signed [2:0] INDEL_NONE    = 3'sd0;
	localparam logic signed [2:0] INDEL_DEL_ONE = -3'sd1;
	localparam logic signed [2:0] INDEL_INS_ONE = 3'sd1;

	// Request payload as packed in tdata, highest field first
	typedef struct packed {
		logic                has_next_base;
		logic [FILE_W-1:0]   file_index;
		logic [QUAL_W-1:0]   next_quality;
		logic [QUAL_W-1:0]   quality;
		logic [BASE_W-1:0]   next_genome_base;
		logic [BASE_W-1:0]   genome_base;
		logic [BASE_W-1:0]   next_read_base;
		logic [BASE_W-1:0]   read_base;
		logic signed [2:0]   indel;
		logic                reversed;
	} item_t;

	// One counter update produced by the key decoder
	typedef struct packed {
		logic              valid;
		logic [KEY_W-1:0]  key;
		logic [QUAL_W-1:0] qual;
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ERR_RD,
		ST_ERR_WR,
		ST_HIST_RD,
		ST_HIST_WR,
		ST_DUMP_RD,
		ST_DUMP_WR
	} state_t;

endpackage

// ----- design/beh_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module beh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port, holds while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ----- design/beh_keys.sv -----
// Key decoder: turns one aligned base into at most two counter updates.
module beh_keys (
	input  logic          enable,
	input  beh_pkg::item_t item,
	output beh_pkg::op_t   pair_op,
	output beh_pkg::op_t   gap_op
);
	import beh_pkg::*;

	logic [1:0]        ref_sym;
	logic [1:0]        obs_sym;
	logic [1:0]        del_sym;
	logic [1:0]        ins_sym;
	logic [BASE_W-1:0] step_read;
	logic [BASE_W-1:0] step_ref;
	logic [QUAL_W-1:0] step_qual;

	function automatic logic [KEY_W-1:0] key_of(input logic [1:0] r, input logic [BASE_W-1:0] o);
		return KEY_W'({r, 2'b00}) + KEY_W'(r) + KEY_W'(o);
	endfunction

	// Complement symbols on the reverse strand
	assign ref_sym = item.reversed ? ~item.genome_base[1:0]      : item.genome_base[1:0];
	assign obs_sym = item.reversed ? ~item.read_base[1:0]        : item.read_base[1:0];
	assign del_sym = item.reversed ? ~item.next_genome_base[1:0] : item.next_genome_base[1:0];
	assign ins_sym = item.reversed ? ~item.next_read_base[1:0]   : item.next_read_base[1:0];

	// Reverse strand takes the step from the current base
	assign step_read = item.reversed ? item.read_base   : item.next_read_base;
	assign step_ref  = item.reversed ? item.genome_base : item.next_genome_base;
	assign step_qual = item.reversed ? item.quality     : item.next_quality;

	// Match or substitution pair
	always_comb begin
		pair_op.valid = enable && !item.read_base[2] && !item.genome_base[2];
		pair_op.key   = key_of(ref_sym, {1'b0, obs_sym});
		pair_op.qual  = item.quality;
	end

	// Gap key: step, single deletion or single insertion
	always_comb begin
		gap_op.valid = 1'b0;
		gap_op.key   = KEY_GAP_GAP;
		gap_op.qual  = step_qual;
		unique case (item.indel)
			INDEL_NONE: begin
				gap_op.valid = enable && item.has_next_base && !step_read[2] && !step_ref[2];
			end
			INDEL_DEL_ONE: begin
				gap_op.valid = enable && !step_read[2] && !item.next_genome_base[2];
				gap_op.key   = key_of(del_sym, SYM_GAP);
			end
			INDEL_INS_ONE: begin
				gap_op.valid = enable && item.has_next_base && !item.next_read_base[2];
				gap_op.key   = KEY_INS_BASE + KEY_W'(ins_sym);
				gap_op.qual  = item.next_quality;
			end
			default: begin
				gap_op.valid = 1'b0;
			end
		endcase
	end
endmodule

// ----- design/base_error_histogram_core.sv -----
// Top level of the base error histogram: counter memories, sequencer and stream ports.
//
// channel | direction | handshake          | payload
// s_      | in        | s_tvalid/s_tready  | tdata fields, tuser action, tlast last_in_pileup
// m_      | out       | m_tvalid/m_tready  | tdata count/entry_index, tlast last_entry
// cfg_    | in        | cfg_valid/cfg_ready| cfg_data count_errors
//
// After reset a clearing pass writes zero to every counter, one address per cycle,
// over max(READ_FILES*QUALITY_LEVELS*25, DEPTH_BINS) addresses (6400 by default); no
// request is taken meanwhile. An aligned base is taken in ST_IDLE, then each counter
// update (up to two error counters and one histogram bin) is a read-modify-write on one
// RAM port, a read state then a write state. A readout reads and emits each result in
// turn (25 or DEPTH_BINS results) and waits while a result is held and m_tready is low.
// The result register lets a result wait while the next request is taken.
`include "base_error_histogram_core_defines.svh"

module base_error_histogram_core #(
	parameter int READ_FILES     = 4,
	parameter int QUALITY_LEVELS = 64,
	parameter int DEPTH_BINS     = 64,
	parameter int COUNT_BITS     = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// s_tdata: reversed, indel, read_base, next_read_base, genome_base, next_genome_base,
	//          quality, next_quality, file_index, has_next_base, zero pad
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [beh_pkg::S_DATA_W-1:0]  s_tdata,
	// s_tuser: action
	input  logic [beh_pkg::ACT_W-1:0]     s_tuser,
	input  logic                          s_tlast,
	// m_tdata: count, entry_index, zero pad
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [beh_pkg::M_DATA_W-1:0]  m_tdata,
	output logic                          m_tlast,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_data
);
	import beh_pkg::*;

	localparam int ROWS      = READ_FILES * QUALITY_LEVELS;
	localparam int ROW_W     = $clog2(ROWS);
	localparam int ERR_DEPTH = ROWS * KEYS;
	localparam int ERR_AW    = $clog2(ERR_DEPTH);
	localparam int HIST_AW   = $clog2(DEPTH_BINS);
	localparam int CLR_N     = (ERR_DEPTH > DEPTH_BINS) ? ERR_DEPTH : DEPTH_BINS;
	localparam int CLR_W     = $clog2(CLR_N);

	state_t state_q, state_d;

	item_t             item;
	logic              accept;
	logic              is_update;
	logic              file_ok;
	op_t               pair_op, gap_op;
	logic              pair_ok, gap_ok;
	logic              slot0_v, slot1_v;
	logic [ROW_W-1:0]  slot0_row, slot1_row;
	logic [KEY_W-1:0]  slot0_key, slot1_key;

	// Position tracking
	logic [HIST_AW-1:0] depth_q, depth_next;
	logic               red_q, red_next;
	logic               hist_go;

	// Pending updates
	logic               op0_v_q, op1_v_q, hist_v_q;
	logic [ROW_W-1:0]   op0_row_q, op1_row_q;
	logic [KEY_W-1:0]   op0_key_q, op1_key_q;
	logic [HIST_AW-1:0] hist_bin_q;
	logic [ERR_AW-1:0]  err_waddr_q;

	// Readout
	logic               dump_hist_q, dump_ok_q;
	logic [ROW_W-1:0]   dump_row_q;
	logic [IDX_W-1:0]   k_q;
	logic               dump_last;
	logic [COUNT_BITS-1:0] dump_val;
	logic [63:0]        dump_wide;
	logic [OUT_W-1:0]   dump_count;

	logic [CLR_W-1:0]   clr_q;
	logic               count_errors_q;

	// Memory ports
	logic                  err_we, err_re, hist_we, hist_re;
	logic [ERR_AW-1:0]     err_waddr, err_raddr;
	logic [COUNT_BITS-1:0] err_wdata, err_rdata;
	logic [HIST_AW-1:0]    hist_waddr, hist_raddr;
	logic [COUNT_BITS-1:0] hist_wdata, hist_rdata;
	logic [ROW_W-1:0]      row_sel;
	logic [KEY_W-1:0]      key_sel;

	logic m_tvalid_q, m_last_q, out_load;
	logic [OUT_W-1:0] m_count_q;
	logic [IDX_W-1:0] m_index_q;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
		return (&v) ? v : v + COUNT_BITS'(1);
	endfunction

	function automatic logic [ROW_W-1:0] row_of(input logic [FILE_W-1:0] f,
	                                            input logic [QUAL_W-1:0] q);
		return ROW_W'(32'(f) * 32'(QUALITY_LEVELS) + 32'(q));
	endfunction

	// Unpack the request
	assign item      = item_t'(s_tdata[$bits(item_t)-1:0]);
	assign accept    = s_tvalid && s_tready;
	assign is_update = (s_tuser == ACT_BASE) || (s_tuser == ACT_DELETION) ||
	                   (s_tuser == ACT_REDUNDANT);
	assign file_ok   = 32'(item.file_index) < READ_FILES;

	beh_keys u_keys (
		.enable  (count_errors_q && (s_tuser == ACT_BASE)),
		.item    (item),
		.pair_op (pair_op),
		.gap_op  (gap_op)
	);

	// Drop updates that fall outside the table, then pack the survivors into slot 0 first
	assign pair_ok   = pair_op.valid && file_ok && (32'(pair_op.qual) < QUALITY_LEVELS);
	assign gap_ok    = gap_op.valid && file_ok && (32'(gap_op.qual) < QUALITY_LEVELS);
	assign slot0_v   = pair_ok || gap_ok;
	assign slot1_v   = pair_ok && gap_ok;
	assign slot0_row = pair_ok ? row_of(item.file_index, pair_op.qual)
	                           : row_of(item.file_index, gap_op.qual);
	assign slot0_key = pair_ok ? pair_op.key : gap_op.key;
	assign slot1_row = row_of(item.file_index, gap_op.qual);
	assign slot1_key = gap_op.key;

	// Advance the position depth and decide on a histogram bump
	assign red_next   = red_q || (s_tuser == ACT_REDUNDANT);
	assign depth_next = ((s_tuser == ACT_BASE) && (depth_q != HIST_AW'(DEPTH_BINS - 1))) ?
	                    depth_q + HIST_AW'(1) : depth_q;
	assign hist_go    = s_tlast && !red_next;

	// Shared address computation for the error table
	assign row_sel   = (state_q == ST_DUMP_RD) ? dump_row_q : op0_row_q;
	assign key_sel   = (state_q == ST_DUMP_RD) ? k_q[KEY_W-1:0] : op0_key_q;
	assign err_raddr = ERR_AW'(32'(row_sel) * 32'(KEYS) + 32'(key_sel));

	// Readout value, clipped to the output width
	assign dump_last  = k_q == (dump_hist_q ? IDX_W'(DEPTH_BINS - 1) : IDX_W'(KEYS - 1));
	assign dump_val   = dump_hist_q ? hist_rdata : (dump_ok_q ? err_rdata : '0);
	assign dump_wide  = 64'(dump_val);
	assign dump_count = (|dump_wide[63:OUT_W]) ? '1 : dump_wide[OUT_W-1:0];

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory controls
	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		err_we     = 1'b0;
		err_waddr  = err_waddr_q;
		err_wdata  = sat_inc(err_rdata);
		err_re     = 1'b0;
		hist_we    = 1'b0;
		hist_waddr = hist_bin_q;
		hist_wdata = sat_inc(hist_rdata);
		hist_re    = 1'b0;
		hist_raddr = hist_bin_q;
		out_load   = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				err_we     = 32'(clr_q) < ERR_DEPTH;
				err_waddr  = clr_q[ERR_AW-1:0];
				err_wdata  = '0;
				hist_we    = 32'(clr_q) < DEPTH_BINS;
				hist_waddr = clr_q[HIST_AW-1:0];
				hist_wdata = '0;
				if (clr_q == CLR_W'(CLR_N - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					priority if ((s_tuser == ACT_READ_ERR) || (s_tuser == ACT_READ_HIST)) begin
						state_d = ST_DUMP_RD;
					end else if (is_update && slot0_v) begin
						state_d = ST_ERR_RD;
					end else if (is_update && hist_go) begin
						state_d = ST_HIST_RD;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_ERR_RD: begin
				err_re  = 1'b1;
				state_d = ST_ERR_WR;
			end
			ST_ERR_WR: begin
				err_we = 1'b1;
				priority if (op1_v_q) begin
					state_d = ST_ERR_RD;
				end else if (hist_v_q) begin
					state_d = ST_HIST_RD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_HIST_RD: begin
				hist_re = 1'b1;
				state_d = ST_HIST_WR;
			end
			ST_HIST_WR: begin
				hist_we = 1'b1;
				state_d = ST_IDLE;
			end
			ST_DUMP_RD: begin
				hist_re    = dump_hist_q;
				hist_raddr = k_q[HIST_AW-1:0];
				err_re     = !dump_hist_q;
				state_d    = ST_DUMP_WR;
			end
			ST_DUMP_WR: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = dump_last ? ST_IDLE : ST_DUMP_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q          <= '0;
			count_errors_q <= 1'b1;
			depth_q        <= '0;
			red_q          <= 1'b0;
			op0_v_q        <= 1'b0;
			op1_v_q        <= 1'b0;
			hist_v_q       <= 1'b0;
			dump_hist_q    <= 1'b0;
			k_q            <= '0;
			m_tvalid_q     <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + CLR_W'(1);
			end
			if (cfg_valid) begin
				count_errors_q <= cfg_data;
			end
			// Take a request: update the position and queue counter work
			if (accept && is_update) begin
				op0_v_q  <= slot0_v;
				op1_v_q  <= slot1_v;
				hist_v_q <= hist_go;
				if (s_tlast) begin
					depth_q <= '0;
					red_q   <= 1'b0;
				end else begin
					depth_q <= depth_next;
					red_q   <= red_next;
				end
			end
			if (accept && ((s_tuser == ACT_READ_ERR) || (s_tuser == ACT_READ_HIST))) begin
				dump_hist_q <= s_tuser == ACT_READ_HIST;
				k_q         <= '0;
			end
			// Retire the finished error update
			if (state_q == ST_ERR_WR) begin
				op0_v_q <= op1_v_q;
				op1_v_q <= 1'b0;
			end
			if (state_q == ST_HIST_WR) begin
				hist_v_q <= 1'b0;
			end
			if (out_load) begin
				k_q <= k_q + IDX_W'(1);
			end
			// Hold a result until taken
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept && is_update) begin
			op0_row_q  <= slot0_row;
			op0_key_q  <= slot0_key;
			op1_row_q  <= slot1_row;
			op1_key_q  <= slot1_key;
			hist_bin_q <= depth_next;
		end
		if (accept && (s_tuser == ACT_READ_ERR)) begin
			dump_ok_q  <= file_ok && (32'(item.quality) < QUALITY_LEVELS);
			dump_row_q <= (file_ok && (32'(item.quality) < QUALITY_LEVELS)) ?
			              row_of(item.file_index, item.quality) : '0;
		end
		if (state_q == ST_ERR_RD) begin
			err_waddr_q <= err_raddr;
		end
		if (state_q == ST_ERR_WR) begin
			op0_row_q <= op1_row_q;
			op0_key_q <= op1_key_q;
		end
		if (out_load) begin
			m_count_q <= dump_count;
			m_index_q <= k_q;
			m_last_q  <= dump_last;
		end
	end

	beh_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (ERR_DEPTH)
	) u_err_ram (
		.clk   (clk),
		.we    (err_we),
		.waddr (err_waddr),
		.wdata (err_wdata),
		.re    (err_re),
		.raddr (err_raddr),
		.rdata (err_rdata)
	);

	beh_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (DEPTH_BINS)
	) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (hist_wdata),
		.re    (hist_re),
		.raddr (hist_raddr),
		.rdata (hist_rdata)
	);

	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tlast   = m_last_q;
	assign m_tdata   = {{(M_DATA_W - OUT_W - IDX_W){1'b0}}, m_index_q, m_count_q};

	`BEH_ASSERT_NOW(a_wr_follows_rd, state_q == ST_ERR_WR, $past(state_q) == ST_ERR_RD,
		"error counter write without a preceding read")
	`BEH_ASSERT_NOW(a_result_from_dump, $rose(m_tvalid_q), $past(state_q) == ST_DUMP_WR,
		"result raised outside a readout")
	`BEH_ASSERT_NOW(a_clear_complete, (state_q == ST_IDLE) && ($past(state_q) == ST_CLEAR),
		$past(clr_q) == CLR_W'(CLR_N - 1), "clearing pass left early")
	`BEH_ASSERT_NOW(a_slots_packed, op1_v_q, op0_v_q, "second update queued without a first")
	`BEH_ASSERT_NEXT(a_hist_after_err, (state_q == ST_ERR_WR) && !op1_v_q && hist_v_q,
		state_q == ST_HIST_RD, "histogram update skipped after error updates")
endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the base error histogram core: directed rows, random pileups.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import beh_pkg::*;

	localparam int READ_FILES     = 4;
	localparam int QUALITY_LEVELS = 64;
	localparam int DEPTH_BINS     = 64;
	localparam int COUNT_BITS     = 32;
	localparam int ROW_SLOTS      = READ_FILES * QUALITY_LEVELS * KEYS;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 600;
	localparam int PHASE_ITEMS   = 100;
	localparam int PHASES        = 5;

	// Base codes; anything with the top bit set reads as N
	localparam logic [BASE_W-1:0] BASE_A      = 3'd0;
	localparam logic [BASE_W-1:0] BASE_C      = 3'd1;
	localparam logic [BASE_W-1:0] BASE_G      = 3'd2;
	localparam logic [BASE_W-1:0] BASE_T      = 3'd3;
	localparam logic [BASE_W-1:0] BASE_N      = 3'd4;
	localparam logic [BASE_W-1:0] BASE_N_HIGH = 3'd7;

	// Request kinds the core ignores
	localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd5;
	localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

	// Indel lengths that add no indel count
	localparam logic signed [2:0] INDEL_MIN      = -3'sd4;
	localparam logic signed [2:0] INDEL_MAX      = 3'sd3;
	localparam logic signed [2:0] INDEL_LONG_DEL = -3'sd2;
	localparam logic signed [2:0] INDEL_LONG_INS = 3'sd2;

	// One stimulus row; zeros marks a readout whose counts are all zero by construction
	typedef struct packed {
		logic [ACT_W-1:0]  act;
		logic              rev;
		logic signed [2:0] indel;
		logic [BASE_W-1:0] rb;
		logic [BASE_W-1:0] nrb;
		logic [BASE_W-1:0] fb;
		logic [BASE_W-1:0] nfb;
		logic [QUAL_W-1:0] q;
		logic [QUAL_W-1:0] nq;
		logic [FILE_W-1:0] file;
		logic              hn;
		logic              last;
		logic              zeros;
	} stim_row_t;

	typedef struct packed {
		logic [OUT_W-1:0] count;
		logic [IDX_W-1:0] bin;
		logic             last;
	} count_rec_t;

	// act, rev, indel, rb, nrb, fb, nfb, q, nq, file, hn, last, zeros
	localparam int DIRECTED_ROWS = 24;
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		// empty stores right after reset, nearest and farthest rows
		'{ACT_READ_ERR, 0, INDEL_NONE, BASE_A, BASE_A, BASE_A, BASE_A, 0, 0, 0, 0, 0, 1},
		'{ACT_READ_HIST, 0, INDEL_NONE, BASE_A, BASE_A, BASE_A, BASE_A, 0, 0, 0, 0, 0, 1},
		'{ACT_READ_ERR, 1, INDEL_MAX, BASE_N_HIGH, BASE_N_HIGH, BASE_N_HIGH, BASE_N_HIGH,
			63, 63, 3, 1, 1, 1},
		// match plus step, reverse deletion, insertion with and without a next base
		'{ACT_BASE, 0, INDEL_NONE, BASE_A, BASE_C, BASE_A, BASE_C, 0, 1, 0, 1, 0, 0},
		'{ACT_BASE, 1, INDEL_DEL_ONE, BASE_T, BASE_G, BASE_G, BASE_C, 63, 5, 3, 1, 0, 0},
		'{ACT_BASE, 0, INDEL_INS_ONE, BASE_C, BASE_G, BASE_A, BASE_T, 62, 62, 3, 1, 0, 0},
		'{ACT_BASE, 0, INDEL_INS_ONE, BASE_C, BASE_G, BASE_A, BASE_T, 62, 62, 3, 0, 0, 0},
		// N bases skip their counts
		'{ACT_BASE, 0, INDEL_NONE, BASE_N, BASE_A, BASE_A, BASE_A, 10, 11, 1, 1, 0, 0},
		'{ACT_BASE, 1, INDEL_NONE, BASE_G, BASE_A, BASE_N, BASE_A, 20, 21, 2, 1, 0, 0},
		'{ACT_BASE, 0, INDEL_DEL_ONE, BASE_A, BASE_A, BASE_C, BASE_N_HIGH, 30, 31, 1, 0, 0, 0},
		// long indels add only the pair count
		'{ACT_BASE, 0, INDEL_LONG_DEL, BASE_A, BASE_C, BASE_A, BASE_C, 40, 41, 0, 1, 0, 0},
		'{ACT_BASE, 1, INDEL_LONG_INS, BASE_T, BASE_T, BASE_T, BASE_T, 40, 41, 0, 1, 0, 0},
		'{ACT_BASE, 0, INDEL_MIN, BASE_G, BASE_G, BASE_C, BASE_C, 50, 51, 2, 1, 0, 0},
		'{ACT_BASE, 1, INDEL_MAX, BASE_C, BASE_A, BASE_G, BASE_T, 50, 51, 2, 1, 0, 0},
		// close a position on a deletion entry, then a redundant position
		'{ACT_DELETION, 0, INDEL_NONE, BASE_A, BASE_A, BASE_A, BASE_A, 0, 0, 0, 0, 1, 0},
		'{ACT_REDUNDANT, 0, INDEL_NONE, BASE_A, BASE_A, BASE_A, BASE_A, 0, 0, 0, 0, 0, 0},
		'{ACT_BASE, 0, INDEL_NONE, BASE_T, BASE_T, BASE_T, BASE_T, 7, 7, 1, 1, 1, 0},
		// ignored kinds must not close a position
		'{ACT_SPARE_LO, 0, INDEL_NONE, BASE_A, BASE_A, BASE_A, BASE_A, 0, 0, 0, 0, 1, 0},
		'{ACT_SPARE_HI, 1, INDEL_MIN, BASE_N_HIGH, BASE_N_HIGH, BASE_N_HIGH, BASE_N_HIGH,
			63, 63, 3, 1, 1, 0},
		'{ACT_BASE, 0, INDEL_NONE, BASE_G, BASE_C, BASE_G, BASE_C, 63, 0, 3, 1, 1, 0},
		// read back what the rows above counted
		'{ACT_READ_HIST, 0, INDEL_NONE, BASE_A, BASE_A, BASE_A, BASE_A, 0, 0, 0, 0, 1, 0},
		'{ACT_READ_ERR, 0, INDEL_NONE, BASE_A, BASE_A, BASE_A, BASE_A, 62, 0, 3, 0, 0, 0},
		'{ACT_READ_ERR, 0, INDEL_NONE, BASE_A, BASE_A, BASE_A, BASE_A, 0, 0, 0, 0, 0, 0},
		'{ACT_READ_ERR, 0, INDEL_NONE, BASE_A, BASE_A, BASE_A, BASE_A, 63, 0, 3, 0, 0, 0}
	};

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [S_DATA_W-1:0]  s_tdata   = '0;
	logic [ACT_W-1:0]     s_tuser   = '0;
	logic                 s_tlast   = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [M_DATA_W-1:0]  m_tdata;
	logic                 m_tlast;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic                 cfg_data  = 1'b0;

	// Model state of the core
	logic [OUT_W-1:0] error_tally [ROW_SLOTS];
	logic [OUT_W-1:0] depth_tally [DEPTH_BINS];
	int unsigned      pos_entries;
	bit               pos_redundant;
	bit               count_en;
	count_rec_t       expected_counts [$];

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	logic        hold_go        = 1'b0;
	logic        hold_on        = 1'b0;
	int unsigned cycle_count    = 0;
	int unsigned results_seen   = 0;
	int unsigned mismatches     = 0;
	int unsigned items_sent     = 0;
	int unsigned readouts_sent  = 0;
	logic [QUAL_W-1:0] qual_pool [4] = '{6'd0, 6'd1, 6'd62, 6'd63};

	base_error_histogram_core #(
		.READ_FILES     (READ_FILES),
		.QUALITY_LEVELS (QUALITY_LEVELS),
		.DEPTH_BINS     (DEPTH_BINS),
		.COUNT_BITS     (COUNT_BITS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// Generate the clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort a run that hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Hold the result side off once for a long stretch
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_on <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_on <= 1'b0;
	end

	// Drive ready on the result side, stalling at random
	always @(posedge clk)
		m_tready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		count_rec_t want;
		count_rec_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.count = m_tdata[OUT_W-1:0];
			got.bin   = m_tdata[OUT_W +: IDX_W];
			got.last  = m_tlast;
			results_seen++;
			if (expected_counts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: count %0d bin %0d last %0b",
						got.count, got.bin, got.last);
			end else begin
				want = expected_counts.pop_front();
				if (got.count !== want.count || got.bin !== want.bin ||
				    got.last !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: expected %0d/%0d/%0b, got %0d/%0d/%0b",
							results_seen, want.count, want.bin, want.last,
							got.count, got.bin, got.last);
				end
			end
		end
	end

	function automatic item_t row_item(stim_row_t r);
		item_t it;
		it.has_next_base    = r.hn;
		it.file_index       = r.file;
		it.next_quality     = r.nq;
		it.quality          = r.q;
		it.next_genome_base = r.nfb;
		it.genome_base      = r.fb;
		it.next_read_base   = r.nrb;
		it.read_base        = r.rb;
		it.indel            = r.indel;
		it.reversed         = r.rev;
		return it;
	endfunction

	// Saturating increment of one error counter; out-of-range rows are dropped
	function automatic void bump_error(logic [FILE_W-1:0] file, logic [QUAL_W-1:0] qual, int key);
		int slot;
		if (int'(file) >= READ_FILES || int'(qual) >= QUALITY_LEVELS || key >= KEYS)
			return;
		slot = (int'(file) * QUALITY_LEVELS + int'(qual)) * KEYS + key;
		if (error_tally[slot] != '1)
			error_tally[slot] = error_tally[slot] + 1'b1;
	endfunction

	// Error counts for one aligned base; complementing a 2-bit code is a bit flip
	function automatic void tally_base(item_t it);
		logic [1:0]        r;
		logic [1:0]        o;
		logic [BASE_W-1:0] sb;
		logic [BASE_W-1:0] sf;
		logic [QUAL_W-1:0] sq;
		if (!it.read_base[BASE_W-1] && !it.genome_base[BASE_W-1]) begin
			r = it.genome_base[1:0];
			o = it.read_base[1:0];
			if (it.reversed) begin
				r = ~r;
				o = ~o;
			end
			bump_error(it.file_index, it.quality, 5 * int'(r) + int'(o));
		end
		// the reverse strand takes the step, and the deletion's read base and quality, from the current base
		sb = it.reversed ? it.read_base : it.next_read_base;
		sq = it.reversed ? it.quality : it.next_quality;
		if (it.indel == INDEL_NONE) begin
			sf = it.reversed ? it.genome_base : it.next_genome_base;
			if (it.has_next_base && !sb[BASE_W-1] && !sf[BASE_W-1])
				bump_error(it.file_index, sq, int'(KEY_GAP_GAP));
		end else if (it.indel == INDEL_DEL_ONE) begin
			if (!sb[BASE_W-1] && !it.next_genome_base[BASE_W-1]) begin
				r = it.reversed ? ~it.next_genome_base[1:0] : it.next_genome_base[1:0];
				bump_error(it.file_index, sq, 5 * int'(r) + int'(SYM_GAP));
			end
		end else if (it.indel == INDEL_INS_ONE) begin
			if (it.has_next_base && !it.next_read_base[BASE_W-1]) begin
				o = it.reversed ? ~it.next_read_base[1:0] : it.next_read_base[1:0];
				bump_error(it.file_index, it.next_quality, int'(KEY_INS_BASE) + int'(o));
			end
		end
	endfunction

	// Advance the model by one request and queue the counts it reads out
	function automatic void predict_counts(stim_row_t r);
		count_rec_t rec;
		int         row_base;
		int         k;
		row_base = (int'(r.file) * QUALITY_LEVELS + int'(r.q)) * KEYS;
		if (r.act == ACT_READ_ERR) begin
			for (k = 0; k < KEYS; k++) begin
				rec.count = r.zeros ? '0 : error_tally[row_base + k];
				rec.bin   = IDX_W'(k);
				rec.last  = (k == KEYS - 1);
				expected_counts.push_back(rec);
			end
			return;
		end
		if (r.act == ACT_READ_HIST) begin
			for (k = 0; k < DEPTH_BINS; k++) begin
				rec.count = r.zeros ? '0 : depth_tally[k];
				rec.bin   = IDX_W'(k);
				rec.last  = (k == DEPTH_BINS - 1);
				expected_counts.push_back(rec);
			end
			return;
		end
		if (r.act > ACT_READ_HIST)
			return;
		if (r.act == ACT_REDUNDANT) begin
			pos_redundant = 1'b1;
		end else if (r.act == ACT_BASE) begin
			if (pos_entries < DEPTH_BINS - 1)
				pos_entries++;
			if (count_en)
				tally_base(row_item(r));
		end
		// close the position
		if (r.last) begin
			if (!pos_redundant && depth_tally[pos_entries] != '1)
				depth_tally[pos_entries] = depth_tally[pos_entries] + 1'b1;
			pos_entries   = 0;
			pos_redundant = 1'b0;
		end
	endfunction

	function automatic logic [BASE_W-1:0] pick_base();
		if ($urandom_range(99) < 85)
			return BASE_W'($urandom_range(BASE_T, BASE_A));
		return BASE_W'($urandom_range(BASE_N_HIGH, BASE_N));
	endfunction

	function automatic logic signed [2:0] pick_indel();
		int roll;
		roll = $urandom_range(9);
		if (roll < 5)
			return INDEL_NONE;
		if (roll < 7)
			return INDEL_DEL_ONE;
		if (roll < 9)
			return INDEL_INS_ONE;
		return 3'($urandom_range(7));
	endfunction

	// Mostly a few shared qualities so readouts find counts
	function automatic logic [QUAL_W-1:0] pick_quality();
		if ($urandom_range(99) < 65)
			return qual_pool[$urandom_range(3)];
		return QUAL_W'($urandom_range(QUALITY_LEVELS - 1));
	endfunction

	function automatic stim_row_t random_row(logic [ACT_W-1:0] act);
		stim_row_t r;
		r.act   = act;
		r.rev   = 1'($urandom_range(1));
		r.indel = pick_indel();
		r.rb    = pick_base();
		r.nrb   = pick_base();
		r.fb    = pick_base();
		r.nfb   = pick_base();
		r.q     = pick_quality();
		r.nq    = pick_quality();
		r.file  = FILE_W'($urandom_range(READ_FILES - 1));
		r.hn    = ($urandom_range(99) < 80);
		r.last  = 1'($urandom_range(1));
		r.zeros = 1'b0;
		return r;
	endfunction

	// Offer one request, wait for it to be taken, then predict its results
	task automatic send_row(stim_row_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_DATA_W - $bits(item_t)){1'b0}}, row_item(r)};
		s_tuser  <= r.act;
		s_tlast  <= r.last;
		do @(posedge clk); while (!s_tready);
		predict_counts(r);
		if (r.act <= ACT_READ_HIST)
			items_sent++;
		if (r.act == ACT_READ_ERR || r.act == ACT_READ_HIST)
			readouts_sent++;
	endtask

	// Send one reference position; now and then leave it open or close it early
	task automatic send_position(int depth);
		stim_row_t r;
		int        k;
		int        roll;
		logic [ACT_W-1:0] act;
		for (k = 0; k < depth; k++) begin
			roll = $urandom_range(99);
			if (roll < 80)
				act = ACT_BASE;
			else if (roll < 88)
				act = ACT_DELETION;
			else if (roll < 94 || k == depth - 1)
				act = ACT_REDUNDANT;
			else
				act = ACT_W'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
			r = random_row(act);
			if (act < ACT_SPARE_LO)
				r.last = (k == depth - 1) ? ($urandom_range(19) != 0) : ($urandom_range(49) == 0);
			send_row(r);
		end
	endtask

	task automatic send_readout(logic [ACT_W-1:0] act);
		send_row(random_row(act));
	endtask

	// Stop offering and let every expected result and pending update come out
	task automatic settle_block();
		s_tvalid <= 1'b0;
		while (expected_counts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_count_enable(logic en);
		cfg_valid <= 1'b1;
		cfg_data  <= en;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		count_en = en;
	endtask

	// Main sequence: reset, directed rows, then random phases
	initial begin
		int          ph;
		int unsigned phase_start;
		int          roll;
		foreach (error_tally[i])
			error_tally[i] = '0;
		foreach (depth_tally[i])
			depth_tally[i] = '0;
		pos_entries   = 0;
		pos_redundant = 1'b0;
		count_en      = 1'b1;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIRECTED_ROWS; i++)
			send_row(DIRECTED[i]);
		settle_block();

		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					write_count_enable(1'b0);
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					write_count_enable(1'b1);
					send_idle_pct  = 62;
					recv_stall_pct = 0;
				end
				2: begin
					write_count_enable(1'b1);
					send_idle_pct  = 0;
					recv_stall_pct = 62;
				end
				3: begin
					write_count_enable(1'b0);
					send_idle_pct  = 34;
					recv_stall_pct = 34;
				end
				default: begin
					write_count_enable(1'b1);
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
			endcase
			phase_start = items_sent;
			// a deep position drives the depth counter toward saturation
			if (ph == 0)
				send_position(70);
			// fill the core behind a held-off readout
			if (ph == PHASES - 1) begin
				hold_go <= 1'b1;
				send_readout(ACT_READ_HIST);
			end
			while (items_sent - phase_start < PHASE_ITEMS) begin
				roll = $urandom_range(99);
				if (roll < 18)
					send_readout(($urandom_range(99) < 70) ? ACT_READ_ERR : ACT_READ_HIST);
				else if (roll < 26)
					send_row(random_row(ACT_W'($urandom_range(ACT_SPARE_HI, ACT_BASE))));
				else if (roll < 29)
					send_position($urandom_range(70, 64));
				else
					send_position($urandom_range(6, 1));
			end
			settle_block();
		end

		$display("Sent %0d requests (%0d readouts) and checked %0d results,",
			items_sent, readouts_sent, results_seen);
		$display("with counting on and off, sender gaps, result stalls and one long hold-off.");
		if (mismatches == 0 && expected_counts.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+design
design/beh_pkg.sv
design/beh_ram.sv
design/beh_keys.sv
design/base_error_histogram_core.sv
verif/testbench.sv
